FILE: rtl/d6ofe_pkg.sv
// Shared types, codes and result builders for the DHCPv6 option field extractor.
package d6ofe_pkg;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_IA_NA,
    CLS_IA_TA,
    CLS_ORO,
    CLS_VENDOR
  } cls_t;

  localparam logic [1:0] KIND_MSG_START = 2'd0;
  localparam logic [1:0] KIND_OPT_START = 2'd1;
  localparam logic [1:0] KIND_VALUE     = 2'd2;

  localparam logic [15:0] CODE_IA_NA  = 16'd3;
  localparam logic [15:0] CODE_IA_TA  = 16'd4;
  localparam logic [15:0] CODE_IAADDR = 16'd5;
  localparam logic [15:0] CODE_ORO    = 16'd6;
  localparam logic [15:0] CODE_VENDOR = 16'd17;

  localparam logic [15:0] IA_NA_HDR = 16'd12;
  localparam logic [15:0] IA_TA_HDR = 16'd4;
  localparam logic [15:0] ENT_LEN   = 16'd4;
  localparam logic [15:0] ADDR_LEN  = 16'd16;
  localparam logic [15:0] SUBHDR_LEN = 16'd4;

  localparam logic [2:0] RK_ADDR = 3'd0;
  localparam logic [2:0] RK_ORO  = 3'd1;
  localparam logic [2:0] RK_ENT  = 3'd2;
  localparam logic [2:0] RK_VSUB = 3'd3;
  localparam logic [2:0] RK_WARN = 3'd4;

  localparam logic [2:0] W_IA_SHORT     = 3'd0;
  localparam logic [2:0] W_IAADDR_SHORT = 3'd1;
  localparam logic [2:0] W_IA_OVERRUN   = 3'd2;
  localparam logic [2:0] W_ORO_ODD      = 3'd3;
  localparam logic [2:0] W_VEND_SHORT   = 3'd4;
  localparam logic [2:0] W_VEND_OVERRUN = 3'd5;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [15:0] code_value;
    logic [15:0] length_value;
    logic [31:0] enterprise;
    logic [2:0]  warning_code;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t res_warn(logic [2:0] code);
    res_t r;
    r = '0;
    r.result_kind  = RK_WARN;
    r.warning_code = code;
    return r;
  endfunction

  function automatic res_t res_code(logic [2:0] kind, logic [15:0] code, logic [15:0] len);
    res_t r;
    r = '0;
    r.result_kind  = kind;
    r.code_value   = code;
    r.length_value = len;
    return r;
  endfunction

endpackage

FILE: rtl/d6ofe_core.sv
// Option walker: state registers and the per-word decode that yields up to two results.
module d6ofe_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_acc,
  input  logic [1:0]           in_kind,
  input  logic [15:0]          in_option_code,
  input  logic [15:0]          in_option_length,
  input  logic [7:0]           in_data_byte,
  output d6ofe_pkg::push_t     push
);

  d6ofe_pkg::cls_t cls_r, cls_nxt;
  logic [15:0]  bytes_left_r, bytes_left_nxt;
  logic [15:0]  byte_pos_r, byte_pos_nxt;
  logic [23:0]  sub_header_r, sub_header_nxt;
  logic [15:0]  sub_left_r, sub_left_nxt;
  logic         sub_is_addr_r, sub_is_addr_nxt;
  logic         walk_stop_r, walk_stop_nxt;
  logic [119:0] addr_shift_r, addr_shift_nxt;
  logic [23:0]  word_shift_r, word_shift_nxt;
  logic         vendor_seen_r, vendor_seen_nxt;
  logic [1:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic [3:0]   addr_cnt_r, addr_cnt_nxt;

  logic         e0_v, e1_v;
  d6ofe_pkg::res_t e0, e1;
  logic [15:0]  bl_dec, decl, use_len;
  logic         over, walk_en, walk_vendor;

  always_comb begin
    cls_nxt         = cls_r;
    bytes_left_nxt  = bytes_left_r;
    byte_pos_nxt    = byte_pos_r;
    sub_header_nxt  = sub_header_r;
    sub_left_nxt    = sub_left_r;
    sub_is_addr_nxt = sub_is_addr_r;
    walk_stop_nxt   = walk_stop_r;
    addr_shift_nxt  = addr_shift_r;
    word_shift_nxt  = word_shift_r;
    vendor_seen_nxt = vendor_seen_r;
    hdr_cnt_nxt     = hdr_cnt_r;
    addr_cnt_nxt    = addr_cnt_r;
    e0_v = 1'b0;
    e1_v = 1'b0;
    e0   = '0;
    e1   = '0;
    walk_en     = 1'b0;
    walk_vendor = 1'b0;
    bl_dec  = bytes_left_r - 16'd1;
    decl    = {sub_header_r[7:0], in_data_byte};
    over    = decl > bl_dec;
    use_len = over ? bl_dec : decl;
    push    = '0;

    if (in_acc && (in_kind == d6ofe_pkg::KIND_MSG_START ||
                   in_kind == d6ofe_pkg::KIND_OPT_START)) begin
      cls_nxt         = d6ofe_pkg::CLS_NONE;
      bytes_left_nxt  = '0;
      byte_pos_nxt    = '0;
      sub_header_nxt  = '0;
      sub_left_nxt    = '0;
      sub_is_addr_nxt = 1'b0;
      walk_stop_nxt   = 1'b0;
      addr_shift_nxt  = '0;
      word_shift_nxt  = '0;
      hdr_cnt_nxt     = '0;
      addr_cnt_nxt    = '0;
    end

    if (in_acc) begin
      case (in_kind)
        d6ofe_pkg::KIND_MSG_START: begin
          vendor_seen_nxt = 1'b0;
        end
        d6ofe_pkg::KIND_OPT_START: begin
          case (in_option_code)
            d6ofe_pkg::CODE_IA_NA, d6ofe_pkg::CODE_IA_TA: begin
              if (in_option_length < ((in_option_code == d6ofe_pkg::CODE_IA_NA) ?
                                      d6ofe_pkg::IA_NA_HDR : d6ofe_pkg::IA_TA_HDR)) begin
                e0_v = 1'b1;
                e0   = d6ofe_pkg::res_warn(d6ofe_pkg::W_IA_SHORT);
              end else begin
                cls_nxt = (in_option_code == d6ofe_pkg::CODE_IA_NA) ?
                          d6ofe_pkg::CLS_IA_NA : d6ofe_pkg::CLS_IA_TA;
                bytes_left_nxt = in_option_length;
              end
            end
            d6ofe_pkg::CODE_ORO: begin
              if (in_option_length[0]) begin
                e0_v = 1'b1;
                e0   = d6ofe_pkg::res_warn(d6ofe_pkg::W_ORO_ODD);
              end
              cls_nxt        = d6ofe_pkg::CLS_ORO;
              bytes_left_nxt = in_option_length;
            end
            d6ofe_pkg::CODE_VENDOR: begin
              if (!vendor_seen_r) begin
                vendor_seen_nxt = 1'b1;
                if (in_option_length < d6ofe_pkg::ENT_LEN) begin
                  e0_v = 1'b1;
                  e0   = d6ofe_pkg::res_warn(d6ofe_pkg::W_VEND_SHORT);
                end else begin
                  cls_nxt        = d6ofe_pkg::CLS_VENDOR;
                  bytes_left_nxt = in_option_length;
                end
              end
            end
            default: ;
          endcase
        end
        d6ofe_pkg::KIND_VALUE: begin
          if (cls_r != d6ofe_pkg::CLS_NONE && bytes_left_r != 16'd0) begin
            bytes_left_nxt = bl_dec;
            byte_pos_nxt   = byte_pos_r + 16'd1;
            case (cls_r)
              d6ofe_pkg::CLS_IA_NA: walk_en = byte_pos_r >= d6ofe_pkg::IA_NA_HDR;
              d6ofe_pkg::CLS_IA_TA: walk_en = byte_pos_r >= d6ofe_pkg::IA_TA_HDR;
              d6ofe_pkg::CLS_ORO: begin
                word_shift_nxt = {word_shift_r[15:0], in_data_byte};
                if (byte_pos_r[0]) begin
                  e0_v = 1'b1;
                  e0   = d6ofe_pkg::res_code(d6ofe_pkg::RK_ORO,
                                             {word_shift_r[7:0], in_data_byte}, 16'd0);
                end
              end
              d6ofe_pkg::CLS_VENDOR: begin
                if (byte_pos_r < d6ofe_pkg::ENT_LEN) begin
                  word_shift_nxt = {word_shift_r[15:0], in_data_byte};
                  if (byte_pos_r == d6ofe_pkg::ENT_LEN - 16'd1) begin
                    e0_v = 1'b1;
                    e0.result_kind = d6ofe_pkg::RK_ENT;
                    e0.enterprise  = {word_shift_r, in_data_byte};
                  end
                end else begin
                  walk_en     = 1'b1;
                  walk_vendor = 1'b1;
                end
              end
              default: ;
            endcase

            if (walk_en) begin
              if (sub_left_r != 16'd0) begin
                sub_left_nxt = sub_left_r - 16'd1;
                if (sub_is_addr_r) begin
                  addr_shift_nxt = {addr_shift_r[111:0], in_data_byte};
                  addr_cnt_nxt   = addr_cnt_r + 4'd1;
                  if (addr_cnt_r == 4'd15) begin
                    e0_v = 1'b1;
                    e0.result_kind  = d6ofe_pkg::RK_ADDR;
                    e0.address_high = addr_shift_r[119:56];
                    e0.address_low  = {addr_shift_r[55:0], in_data_byte};
                    sub_is_addr_nxt = 1'b0;
                  end
                end
              end else if (!walk_stop_r) begin
                if (hdr_cnt_r == 2'd0 && bytes_left_r < d6ofe_pkg::SUBHDR_LEN) begin
                  walk_stop_nxt = 1'b1;
                end else begin
                  sub_header_nxt = {sub_header_r[15:0], in_data_byte};
                  hdr_cnt_nxt    = hdr_cnt_r + 2'd1;
                  if (hdr_cnt_r == 2'd3) begin
                    sub_left_nxt = use_len;
                    if (walk_vendor) begin
                      e0_v = 1'b1;
                      e0   = d6ofe_pkg::res_code(d6ofe_pkg::RK_VSUB,
                                                 sub_header_r[23:8], use_len);
                      e1_v = over;
                      e1   = d6ofe_pkg::res_warn(d6ofe_pkg::W_VEND_OVERRUN);
                    end else begin
                      if (sub_header_r[23:8] == d6ofe_pkg::CODE_IAADDR) begin
                        if (use_len >= d6ofe_pkg::ADDR_LEN) begin
                          sub_is_addr_nxt = 1'b1;
                          addr_cnt_nxt    = '0;
                        end else begin
                          e0_v = 1'b1;
                          e0   = d6ofe_pkg::res_warn(d6ofe_pkg::W_IAADDR_SHORT);
                        end
                      end
                      e1_v = over;
                      e1   = d6ofe_pkg::res_warn(d6ofe_pkg::W_IA_OVERRUN);
                    end
                    if (over) begin
                      walk_stop_nxt = 1'b1;
                    end
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (e0_v) begin
      push.r0      = e0;
      push.r0.last = !e1_v;
      push.r1      = e1;
      push.r1.last = 1'b1;
      push.n       = e1_v ? 2'd2 : 2'd1;
    end else if (e1_v) begin
      push.r0      = e1;
      push.r0.last = 1'b1;
      push.n       = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r         <= d6ofe_pkg::CLS_NONE;
      bytes_left_r  <= '0;
      byte_pos_r    <= '0;
      sub_header_r  <= '0;
      sub_left_r    <= '0;
      sub_is_addr_r <= 1'b0;
      walk_stop_r   <= 1'b0;
      addr_shift_r  <= '0;
      word_shift_r  <= '0;
      vendor_seen_r <= 1'b0;
      hdr_cnt_r     <= '0;
      addr_cnt_r    <= '0;
    end else begin
      cls_r         <= cls_nxt;
      bytes_left_r  <= bytes_left_nxt;
      byte_pos_r    <= byte_pos_nxt;
      sub_header_r  <= sub_header_nxt;
      sub_left_r    <= sub_left_nxt;
      sub_is_addr_r <= sub_is_addr_nxt;
      walk_stop_r   <= walk_stop_nxt;
      addr_shift_r  <= addr_shift_nxt;
      word_shift_r  <= word_shift_nxt;
      vendor_seen_r <= vendor_seen_nxt;
      hdr_cnt_r     <= hdr_cnt_nxt;
      addr_cnt_r    <= addr_cnt_nxt;
    end
  end

endmodule

FILE: rtl/d6ofe_outq.sv
// Four-entry result queue: takes up to two results a cycle, hands out one while head_pop is high.
module d6ofe_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  d6ofe_pkg::push_t push,
  output logic             room,
  output logic             head_valid,
  input  logic             head_pop,
  output d6ofe_pkg::res_t  head
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  d6ofe_pkg::res_t q_mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     count_r, count_nxt;
  logic            pop;

  assign room       = count_r <= (PW+1)'(DEPTH - 2);
  assign head_valid = count_r != '0;
  assign head       = q_mem_r[rd_ptr_r];
  assign pop        = head_valid && head_pop;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.n);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + (PW+1)'(push.n) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_mem_r[wr_ptr_r + PW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/dhcpv6_option_field_extractor.sv
// Top level of the DHCPv6 option field extractor: walker plus result queue.
//
// Accepts one input word per clock while in_ready is high. Each word is decoded
// in the cycle it is taken and its zero, one or two results go into a
// four-entry output queue; they are registered there and reach the out_ port
// in order. in_ready is high while the queue has at least two free entries,
// so with out_ready high a word giving one result sustains one word per cycle,
// and the two results of one word leave the queue one at a time. Throughput is
// set by the single read port of the output queue.
module dhcpv6_option_field_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_option_code,
  input  logic [15:0] in_option_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_result_kind,
  output logic [63:0] out_address_high,
  output logic [63:0] out_address_low,
  output logic [15:0] out_code_value,
  output logic [15:0] out_length_value,
  output logic [31:0] out_enterprise,
  output logic [2:0]  out_warning_code,
  output logic        out_last
);

  d6ofe_pkg::push_t push;
  d6ofe_pkg::res_t  head;
  logic             in_acc;

  assign in_acc = in_valid && in_ready;

  d6ofe_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_acc           (in_acc),
    .in_kind          (in_kind),
    .in_option_code   (in_option_code),
    .in_option_length (in_option_length),
    .in_data_byte     (in_data_byte),
    .push             (push)
  );

  d6ofe_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (in_ready),
    .head_valid (out_valid),
    .head_pop   (out_ready),
    .head       (head)
  );

  assign out_result_kind  = head.result_kind;
  assign out_address_high = head.address_high;
  assign out_address_low  = head.address_low;
  assign out_code_value   = head.code_value;
  assign out_length_value = head.length_value;
  assign out_enterprise   = head.enterprise;
  assign out_warning_code = head.warning_code;
  assign out_last         = head.last;

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |=> out_valid)
    else $error("queued result not presented");

  a_empty_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("empty queue refuses input");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> (push.r1.last && !push.r0.last))
    else $error("last flag misplaced on result pair");

  a_push_needs_acc: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> in_acc)
    else $error("result pushed without accepted word");

endmodule

FILE: sim/dhcpv6_option_field_extractor_test.sv
// Self-checking testbench for the DHCPv6 option field extractor: random messages, scoreboard.
class field_tracker;
  d6ofe_pkg::res_t pending[$];
  int              errors;
  d6ofe_pkg::cls_t cls;
  logic [15:0]     left;
  logic [15:0]     pos;
  logic [31:0]     sub_hdr;
  logic [15:0]     sub_left;
  logic            sub_addr;
  logic            stopped;
  logic [63:0]     addr_hi;
  logic [63:0]     addr_lo;
  logic [31:0]     word_sh;
  logic            vend_seen;
  int              hdr_cnt;
  int              addr_cnt;

  task report(string msg);
    errors++;
    $display("MISMATCH %s", msg);
  endtask

  function void clear_option();
    cls      = d6ofe_pkg::CLS_NONE;
    left     = '0;
    pos      = '0;
    sub_hdr  = '0;
    sub_left = '0;
    sub_addr = 1'b0;
    stopped  = 1'b0;
    addr_hi  = '0;
    addr_lo  = '0;
    word_sh  = '0;
    hdr_cnt  = 0;
    addr_cnt = 0;
  endfunction

  function void reset_state();
    clear_option();
    vend_seen = 1'b0;
  endfunction

  function void emit(logic [2:0] k, logic [63:0] hi, logic [63:0] lo, logic [15:0] c,
                     logic [15:0] l, logic [31:0] e, logic [2:0] w);
    d6ofe_pkg::res_t r;
    r = '0;
    r.result_kind  = k;
    r.address_high = hi;
    r.address_low  = lo;
    r.code_value   = c;
    r.length_value = l;
    r.enterprise   = e;
    r.warning_code = w;
    pending.push_back(r);
  endfunction

  function void walk_sub(logic [7:0] b, bit vendor);
    logic [15:0] code;
    logic [15:0] decl;
    logic [15:0] clipped;
    bit          over;
    if (sub_left > 0) begin
      sub_left--;
      if (sub_addr) begin
        addr_hi = {addr_hi[55:0], addr_lo[63:56]};
        addr_lo = {addr_lo[55:0], b};
        addr_cnt++;
        if (addr_cnt >= int'(d6ofe_pkg::ADDR_LEN)) begin
          emit(d6ofe_pkg::RK_ADDR, addr_hi, addr_lo, '0, '0, '0, '0);
          sub_addr = 1'b0;
          addr_cnt = 0;
        end
      end
      return;
    end
    if (stopped) return;
    if (hdr_cnt == 0 && int'(left) + 1 < int'(d6ofe_pkg::SUBHDR_LEN)) begin
      stopped = 1'b1;
      return;
    end
    sub_hdr = {sub_hdr[23:0], b};
    hdr_cnt++;
    if (hdr_cnt < int'(d6ofe_pkg::SUBHDR_LEN)) return;
    hdr_cnt = 0;
    code    = sub_hdr[31:16];
    decl    = sub_hdr[15:0];
    over    = decl > left;
    clipped = over ? left : decl;
    sub_left = clipped;
    if (vendor) begin
      emit(d6ofe_pkg::RK_VSUB, '0, '0, code, clipped, '0, '0);
      if (over) emit(d6ofe_pkg::RK_WARN, '0, '0, '0, '0, '0, d6ofe_pkg::W_VEND_OVERRUN);
    end else begin
      if (code == d6ofe_pkg::CODE_IAADDR) begin
        if (clipped >= d6ofe_pkg::ADDR_LEN) begin
          sub_addr = 1'b1;
          addr_cnt = 0;
        end else begin
          emit(d6ofe_pkg::RK_WARN, '0, '0, '0, '0, '0, d6ofe_pkg::W_IAADDR_SHORT);
        end
      end
      if (over) emit(d6ofe_pkg::RK_WARN, '0, '0, '0, '0, '0, d6ofe_pkg::W_IA_OVERRUN);
    end
    if (over) stopped = 1'b1;
  endfunction

  function void open_option(logic [15:0] code, logic [15:0] len);
    clear_option();
    if (code == d6ofe_pkg::CODE_IA_NA || code == d6ofe_pkg::CODE_IA_TA) begin
      if (len < ((code == d6ofe_pkg::CODE_IA_NA) ? d6ofe_pkg::IA_NA_HDR
                                                 : d6ofe_pkg::IA_TA_HDR)) begin
        emit(d6ofe_pkg::RK_WARN, '0, '0, '0, '0, '0, d6ofe_pkg::W_IA_SHORT);
        return;
      end
      cls = (code == d6ofe_pkg::CODE_IA_NA) ? d6ofe_pkg::CLS_IA_NA : d6ofe_pkg::CLS_IA_TA;
    end else if (code == d6ofe_pkg::CODE_ORO) begin
      if (len[0]) emit(d6ofe_pkg::RK_WARN, '0, '0, '0, '0, '0, d6ofe_pkg::W_ORO_ODD);
      cls = d6ofe_pkg::CLS_ORO;
    end else if (code == d6ofe_pkg::CODE_VENDOR) begin
      if (vend_seen) return;
      vend_seen = 1'b1;
      if (len < d6ofe_pkg::ENT_LEN) begin
        emit(d6ofe_pkg::RK_WARN, '0, '0, '0, '0, '0, d6ofe_pkg::W_VEND_SHORT);
        return;
      end
      cls = d6ofe_pkg::CLS_VENDOR;
    end else begin
      return;
    end
    left = len;
  endfunction

  function void value_byte(logic [7:0] b);
    logic [15:0] p;
    if (cls == d6ofe_pkg::CLS_NONE || left == 0) return;
    left--;
    p   = pos;
    pos = pos + 16'd1;
    case (cls)
      d6ofe_pkg::CLS_IA_NA: begin
        if (p >= d6ofe_pkg::IA_NA_HDR) walk_sub(b, 1'b0);
      end
      d6ofe_pkg::CLS_IA_TA: begin
        if (p >= d6ofe_pkg::IA_TA_HDR) walk_sub(b, 1'b0);
      end
      d6ofe_pkg::CLS_ORO: begin
        word_sh = {16'h0, word_sh[7:0], b};
        if (p[0]) emit(d6ofe_pkg::RK_ORO, '0, '0, word_sh[15:0], '0, '0, '0);
      end
      d6ofe_pkg::CLS_VENDOR: begin
        if (p < d6ofe_pkg::ENT_LEN) begin
          word_sh = {word_sh[23:0], b};
          if (p == d6ofe_pkg::ENT_LEN - 16'd1) begin
            emit(d6ofe_pkg::RK_ENT, '0, '0, '0, '0, word_sh, '0);
          end
        end else begin
          walk_sub(b, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function void take_word(logic [1:0] k, logic [15:0] code, logic [15:0] len, logic [7:0] b);
    int              prior;
    d6ofe_pkg::res_t r;
    prior = pending.size();
    case (k)
      d6ofe_pkg::KIND_MSG_START: reset_state();
      d6ofe_pkg::KIND_OPT_START: open_option(code, len);
      d6ofe_pkg::KIND_VALUE:     value_byte(b);
      default: ;
    endcase
    if (pending.size() > prior) begin
      r = pending.pop_back();
      r.last = 1'b1;
      pending.push_back(r);
    end
  endfunction

  task check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  task match_result(d6ofe_pkg::res_t got);
    d6ofe_pkg::res_t want;
    if (pending.size() == 0) begin
      report($sformatf("result of kind %0d with nothing outstanding", got.result_kind));
      return;
    end
    want = pending.pop_front();
    check_field("result_kind", 64'(got.result_kind), 64'(want.result_kind));
    check_field("address_high", got.address_high, want.address_high);
    check_field("address_low", got.address_low, want.address_low);
    check_field("code_value", 64'(got.code_value), 64'(want.code_value));
    check_field("length_value", 64'(got.length_value), 64'(want.length_value));
    check_field("enterprise", 64'(got.enterprise), 64'(want.enterprise));
    check_field("warning_code", 64'(got.warning_code), 64'(want.warning_code));
    check_field("last", 64'(got.last), 64'(want.last));
  endtask
endclass

module dhcpv6_option_field_extractor_test;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [15:0] in_option_code = '0;
  logic [15:0] in_option_length = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_result_kind;
  logic [63:0] out_address_high;
  logic [63:0] out_address_low;
  logic [15:0] out_code_value;
  logic [15:0] out_length_value;
  logic [31:0] out_enterprise;
  logic [2:0]  out_warning_code;
  logic        out_last;

  field_tracker tracker;
  logic [7:0]   body[$];
  int           words_sent = 0;
  int           stall_left = 0;
  bit           calm = 1'b0;

  dhcpv6_option_field_extractor DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_option_code   (in_option_code),
    .in_option_length (in_option_length),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_address_high (out_address_high),
    .out_address_low  (out_address_low),
    .out_code_value   (out_code_value),
    .out_length_value (out_length_value),
    .out_enterprise   (out_enterprise),
    .out_warning_code (out_warning_code),
    .out_last         (out_last)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    d6ofe_pkg::res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.result_kind  = out_result_kind;
      got.address_high = out_address_high;
      got.address_low  = out_address_low;
      got.code_value   = out_code_value;
      got.length_value = out_length_value;
      got.enterprise   = out_enterprise;
      got.warning_code = out_warning_code;
      got.last         = out_last;
      tracker.match_result(got);
    end
  end

  task automatic send_word(logic [1:0] k, logic [15:0] c, logic [15:0] l, logic [7:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= k;
    in_option_code   <= c;
    in_option_length <= l;
    in_data_byte     <= b;
    do @(posedge clk); while (!in_ready);
    tracker.take_word(k, c, l, b);
    words_sent++;
  endtask

  task automatic start_message();
    send_word(d6ofe_pkg::KIND_MSG_START, 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic start_option(logic [15:0] c, logic [15:0] l);
    send_word(d6ofe_pkg::KIND_OPT_START, c, l, 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(d6ofe_pkg::KIND_VALUE, 16'($urandom), 16'($urandom), b);
  endtask

  task automatic push_u16(logic [15:0] v);
    body.push_back(v[15:8]);
    body.push_back(v[7:0]);
  endtask

  task automatic push_random(int n);
    repeat (n) body.push_back(8'($urandom));
  endtask

  // Declared length and byte count mostly match the body; sometimes skew either.
  task automatic send_option(logic [15:0] code);
    int n;
    int len;
    int sent;
    int r;
    n = body.size();
    r = $urandom_range(0, 9);
    if (r == 0) len = (n > 0) ? $urandom_range(0, n - 1) : 0;
    else if (r == 1) len = n + $urandom_range(1, 5);
    else len = n;
    sent = len;
    r = $urandom_range(0, 11);
    if (r == 0) sent = $urandom_range(0, len);
    else if (r == 1) sent = len + $urandom_range(1, 3);
    start_option(code, 16'(len));
    for (int i = 0; i < sent; i++) send_byte((i < n) ? body[i] : 8'($urandom));
  endtask

  task automatic build_ia(int hdr);
    int          r;
    int          dlen;
    logic [15:0] sc;
    logic [15:0] sl;
    body.delete();
    push_random(hdr);
    repeat ($urandom_range(0, 3)) begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        sc = d6ofe_pkg::CODE_IAADDR;
        sl = 16'($urandom_range(16, 24));
        dlen = int'(sl);
      end else if (r < 15) begin
        sc = d6ofe_pkg::CODE_IAADDR;
        sl = 16'($urandom_range(0, 15));
        dlen = int'(sl);
      end else if (r < 18) begin
        sc = 16'($urandom_range(0, 65535));
        sl = 16'($urandom_range(0, 6));
        dlen = int'(sl);
      end else begin
        sc = d6ofe_pkg::CODE_IAADDR;
        sl = 16'($urandom_range(0, 65535));
        dlen = $urandom_range(16, 20);
      end
      push_u16(sc);
      push_u16(sl);
      push_random(dlen);
    end
    if ($urandom_range(0, 4) == 0) push_random($urandom_range(1, 3));
  endtask

  task automatic build_vendor();
    int          dlen;
    logic [15:0] sl;
    body.delete();
    push_random(4);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 5) == 0) begin
        sl = 16'($urandom_range(0, 65535));
        dlen = $urandom_range(0, 4);
      end else begin
        sl = 16'($urandom_range(0, 6));
        dlen = int'(sl);
      end
      push_u16(16'($urandom));
      push_u16(sl);
      push_random(dlen);
    end
    if ($urandom_range(0, 4) == 0) push_random($urandom_range(1, 3));
  endtask

  task automatic send_noise();
    logic [15:0] c;
    case ($urandom_range(0, 2))
      0: send_word(KIND_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom));
      1: send_byte(8'($urandom));
      default: begin
        case ($urandom_range(0, 4))
          0: c = d6ofe_pkg::CODE_IA_NA;
          1: c = d6ofe_pkg::CODE_IA_TA;
          2: c = d6ofe_pkg::CODE_ORO;
          3: c = d6ofe_pkg::CODE_VENDOR;
          default: c = 16'($urandom);
        endcase
        start_option(c, 16'($urandom));
        repeat ($urandom_range(0, 8)) send_byte(8'($urandom));
      end
    endcase
  endtask

  task automatic send_message();
    int r;
    if ($urandom_range(0, 7) != 0) start_message();
    repeat ($urandom_range(1, 5)) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        build_ia(int'(d6ofe_pkg::IA_NA_HDR));
        send_option(d6ofe_pkg::CODE_IA_NA);
      end else if (r == 3) begin
        build_ia(int'(d6ofe_pkg::IA_TA_HDR));
        send_option(d6ofe_pkg::CODE_IA_TA);
      end else if (r < 6) begin
        body.delete();
        push_random(int'(2 * $urandom_range(0, 5)) + int'($urandom_range(0, 4) == 0));
        send_option(d6ofe_pkg::CODE_ORO);
      end else if (r < 8) begin
        build_vendor();
        send_option(d6ofe_pkg::CODE_VENDOR);
      end else if (r == 8) begin
        body.delete();
        push_random($urandom_range(0, 6));
        send_option(16'($urandom));
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    tracker = new();
    tracker.reset_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    start_message();
    send_word(KIND_UNUSED, 16'hffff, 16'hffff, 8'hff);
    send_byte(8'hff);
    start_option(d6ofe_pkg::CODE_IA_NA, d6ofe_pkg::IA_NA_HDR - 16'd1);
    start_option(d6ofe_pkg::CODE_IA_TA, d6ofe_pkg::IA_TA_HDR - 16'd1);
    start_option(d6ofe_pkg::CODE_ORO, 16'd3);
    send_byte(8'hff);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h00);
    start_option(d6ofe_pkg::CODE_VENDOR, d6ofe_pkg::ENT_LEN - 16'd1);
    start_option(d6ofe_pkg::CODE_VENDOR, 16'd8);
    send_byte(8'h5a);
    start_message();
    start_option(d6ofe_pkg::CODE_VENDOR, 16'hffff);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'hff);
    start_option(16'hffff, 16'h0000);
    start_option(d6ofe_pkg::CODE_ORO, 16'h0000);

    while (words_sent < 860) begin
      if (words_sent > 740) calm = 1'b1;
      send_message();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
